// ===== design/odah_pkg.sv =====
// Shared types and constants for the outline distance and arch height block.
`default_nettype none
package odah_pkg;

  localparam int MAX_VERTICES_DEF = 256;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [24:0] DIST_MAX = 25'h1FF_FFFF;

  // Input mode codes
  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_APPEND = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_NOSEG = 2'd2;

  // Configuration register indexes
  localparam logic REG_MAX_DIST  = 1'b0;
  localparam logic REG_ARCH_PEAK = 1'b1;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_APPEND,
    OP_QUERY,
    OP_NONE
  } op_e;

  typedef struct packed {
    op_e                op;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic               close;
  } item_t;

endpackage
`default_nettype wire

// ===== design/odah_front.sv =====
// Front end: accepts requests, decodes the mode and queues them for the back end.
`default_nettype none
module odah_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         mode_i,
  input  logic signed [23:0] x_i,
  input  logic signed [23:0] y_i,
  input  logic               closes_contour_i,
  output logic               item_valid_o,
  output odah_pkg::item_t    item_o,
  input  logic               item_pop_i
);
  import odah_pkg::*;

  localparam int QAW = $clog2(QUEUE_DEPTH);
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  item_t          fifo_q [QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCW-1:0] count_q;
  item_t          item_in;
  logic           push;

  always_comb begin
    item_in.x     = x_i;
    item_in.y     = y_i;
    item_in.close = closes_contour_i;
    unique case (mode_i)
      MODE_CLEAR:  item_in.op = OP_CLEAR;
      MODE_APPEND: item_in.op = OP_APPEND;
      MODE_QUERY:  item_in.op = OP_QUERY;
      default:     item_in.op = OP_NONE;
    endcase
  end

  assign in_ready_o   = (count_q != QCW'(QUEUE_DEPTH));
  assign push         = in_valid_i && in_ready_o;
  assign item_valid_o = (count_q != '0);
  assign item_o       = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= item_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : QAW'(wr_ptr_q + 1'b1);
      end
      if (item_pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : QAW'(rd_ptr_q + 1'b1);
      end
      if (push && !item_pop_i) begin
        count_q <= QCW'(count_q + 1'b1);
      end else if (!push && item_pop_i) begin
        count_q <= QCW'(count_q - 1'b1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/odah_back.sv =====
// Back end: vertex table, segment distance sequencer, square root and arch height.
`default_nettype none
module odah_back #(
  parameter int MaxVertices = odah_pkg::MAX_VERTICES_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            item_valid_i,
  input  odah_pkg::item_t item_i,
  output logic            item_pop_o,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [24:0]     cfg_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [24:0]     distance_o,
  output logic [23:0]     height_o,
  output logic [1:0]      status_o
);
  import odah_pkg::*;

  localparam int AW = $clog2(MaxVertices);
  localparam int CW = $clog2(MaxVertices + 1);
  localparam logic [CW-1:0] CntMax = CW'(MaxVertices);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_RD   = 5'd1;
  localparam logic [4:0] S_VTX  = 5'd2;
  localparam logic [4:0] S_NEXT = 5'd3;
  localparam logic [4:0] S_DIF  = 5'd4;
  localparam logic [4:0] S_MUL  = 5'd5;
  localparam logic [4:0] S_SUM  = 5'd6;
  localparam logic [4:0] S_DEC  = 5'd7;
  localparam logic [4:0] S_DIV  = 5'd8;
  localparam logic [4:0] S_SCL  = 5'd9;
  localparam logic [4:0] S_DX   = 5'd10;
  localparam logic [4:0] S_SQ   = 5'd11;
  localparam logic [4:0] S_ACC  = 5'd12;
  localparam logic [4:0] S_FIN  = 5'd13;
  localparam logic [4:0] S_SQRT = 5'd14;
  localparam logic [4:0] S_HCHK = 5'd15;
  localparam logic [4:0] S_HU   = 5'd16;
  localparam logic [4:0] S_HM1  = 5'd17;
  localparam logic [4:0] S_HM2  = 5'd18;
  localparam logic [4:0] S_HM3  = 5'd19;
  localparam logic [4:0] S_HOUT = 5'd20;
  localparam logic [4:0] S_DONE = 5'd21;

  logic [4:0]  state_q;
  logic [24:0] dmax_q;
  logic [23:0] peak_q;

  logic [48:0] mem [MaxVertices];
  logic [48:0] rd_q;
  logic        mem_we;

  logic [CW-1:0] cnt_q, k_q;
  logic signed [23:0] px_q, py_q;
  logic [48:0] cur_q, first_q, prev_q;
  logic [47:0] seg_a_q, seg_b_q;
  logic        at_start_q, second_q, cfound_q, gfound_q, hdiv_q;
  logic [52:0] cmin_q, gbest_q;

  logic signed [24:0] abx_q, aby_q, apx_q, apy_q;
  logic signed [49:0] m_ax_q, m_ay_q, m_px_q, m_py_q;
  logic [50:0]        ab2_q;
  logic signed [50:0] dot_q;
  logic [51:0]        div_rem_q;
  logic [50:0]        div_den_q;
  logic [23:0]        div_quo_q;
  logic [4:0]         div_n_q;
  logic signed [25:0] offx_q, offy_q, dx_q, dy_q;
  logic [51:0]        sqx_q, sqy_q;

  logic [52:0] sq_v_q;
  logic [53:0] sq_res_q, sq_bit_q;
  logic [24:0] dist_q, hu_q;
  logic [49:0] hp_q;
  logic [23:0] height_q;
  logic [1:0]  status_q;

  logic        out_valid_q;
  logic [24:0] out_dist_q;
  logic [23:0] out_height_q;
  logic [1:0]  out_status_q;

  // Combinational helpers
  logic signed [23:0] sa_x, sa_y, sb_x, sb_y;
  logic [51:0] div_sh;
  logic        div_ge;
  logic [53:0] sq_trial, sq_res_nx;
  logic        sq_ge;
  logic [24:0] magx, magy;
  logic [49:0] prodx, prody;
  logic [25:0] rndx, rndy;
  logic [52:0] d2;
  logic        start;

  assign sa_x = $signed(seg_a_q[23:0]);
  assign sa_y = $signed(seg_a_q[47:24]);
  assign sb_x = $signed(seg_b_q[23:0]);
  assign sb_y = $signed(seg_b_q[47:24]);

  assign div_sh = {div_rem_q[50:0], 1'b0};
  assign div_ge = (div_sh >= {1'b0, div_den_q});

  assign sq_trial  = sq_res_q + sq_bit_q;
  assign sq_ge     = ({1'b0, sq_v_q} >= sq_trial);
  assign sq_res_nx = sq_ge ? ((sq_res_q >> 1) + sq_bit_q) : (sq_res_q >> 1);

  assign magx  = abx_q[24] ? 25'(-abx_q) : 25'(abx_q);
  assign magy  = aby_q[24] ? 25'(-aby_q) : 25'(aby_q);
  assign prodx = 50'(magx) * 50'(div_quo_q);
  assign prody = 50'(magy) * 50'(div_quo_q);
  assign rndx  = 26'((prodx + 50'd8388608) >> 24);
  assign rndy  = 26'((prody + 50'd8388608) >> 24);

  assign d2 = {1'b0, sqx_q} + {1'b0, sqy_q};

  assign start      = (state_q == S_IDLE) && item_valid_i && !out_valid_q;
  assign item_pop_o = start;
  assign mem_we     = start && (item_i.op == OP_APPEND) && (cnt_q != CntMax);

  assign out_valid_o = out_valid_q;
  assign distance_o  = out_dist_q;
  assign height_o    = out_height_q;
  assign status_o    = out_status_q;

  // Vertex table: one write port, registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[cnt_q[AW-1:0]] <= {item_i.close, item_i.y, item_i.x};
    end
    if (state_q == S_RD) begin
      rd_q <= mem[k_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      dmax_q       <= '0;
      peak_q       <= '0;
      cnt_q        <= '0;
      k_q          <= '0;
      out_valid_q  <= 1'b0;
      at_start_q   <= 1'b1;
      second_q     <= 1'b0;
      cfound_q     <= 1'b0;
      gfound_q     <= 1'b0;
      hdiv_q       <= 1'b0;
      px_q         <= '0;
      py_q         <= '0;
      cur_q        <= '0;
      first_q      <= '0;
      prev_q       <= '0;
      seg_a_q      <= '0;
      seg_b_q      <= '0;
      cmin_q       <= '0;
      gbest_q      <= '0;
      abx_q        <= '0;
      aby_q        <= '0;
      apx_q        <= '0;
      apy_q        <= '0;
      m_ax_q       <= '0;
      m_ay_q       <= '0;
      m_px_q       <= '0;
      m_py_q       <= '0;
      ab2_q        <= '0;
      dot_q        <= '0;
      div_rem_q    <= '0;
      div_den_q    <= '0;
      div_quo_q    <= '0;
      div_n_q      <= '0;
      offx_q       <= '0;
      offy_q       <= '0;
      dx_q         <= '0;
      dy_q         <= '0;
      sqx_q        <= '0;
      sqy_q        <= '0;
      sq_v_q       <= '0;
      sq_res_q     <= '0;
      sq_bit_q     <= '0;
      dist_q       <= '0;
      hu_q         <= '0;
      hp_q         <= '0;
      height_q     <= '0;
      status_q     <= ST_OK;
      out_dist_q   <= '0;
      out_height_q <= '0;
      out_status_q <= ST_OK;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_MAX_DIST) begin
          dmax_q <= cfg_data_i;
        end else if (cfg_idx_i == REG_ARCH_PEAK) begin
          peak_q <= cfg_data_i[23:0];
        end
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            dist_q   <= '0;
            height_q <= '0;
            case (item_i.op)
              OP_CLEAR: begin
                cnt_q    <= '0;
                status_q <= ST_OK;
                state_q  <= S_DONE;
              end
              OP_APPEND: begin
                if (cnt_q != CntMax) begin
                  cnt_q    <= CW'(cnt_q + 1'b1);
                  status_q <= ST_OK;
                end else begin
                  status_q <= ST_FULL;
                end
                state_q <= S_DONE;
              end
              OP_QUERY: begin
                px_q       <= item_i.x;
                py_q       <= item_i.y;
                k_q        <= '0;
                at_start_q <= 1'b1;
                second_q   <= 1'b0;
                gfound_q   <= 1'b0;
                status_q   <= ST_OK;
                state_q    <= (cnt_q == '0) ? S_FIN : S_RD;
              end
              default: begin
                status_q <= ST_OK;
                state_q  <= S_DONE;
              end
            endcase
          end
        end
        S_RD: state_q <= S_VTX;
        S_VTX: begin
          cur_q <= rd_q;
          if (at_start_q) begin
            first_q  <= rd_q;
            prev_q   <= rd_q;
            cfound_q <= 1'b0;
            // a one-vertex ring has no segment: stay at contour start
            at_start_q <= rd_q[48];
            state_q    <= S_NEXT;
          end else begin
            seg_a_q <= prev_q[47:0];
            seg_b_q <= rd_q[47:0];
            state_q <= S_DIF;
          end
        end
        S_NEXT: begin
          if (CW'(k_q + 1'b1) == cnt_q) begin
            state_q <= S_FIN;
          end else begin
            k_q     <= CW'(k_q + 1'b1);
            state_q <= S_RD;
          end
        end
        S_DIF: begin
          abx_q   <= 25'(sb_x) - 25'(sa_x);
          aby_q   <= 25'(sb_y) - 25'(sa_y);
          apx_q   <= 25'(px_q) - 25'(sa_x);
          apy_q   <= 25'(py_q) - 25'(sa_y);
          state_q <= S_MUL;
        end
        S_MUL: begin
          m_ax_q  <= abx_q * abx_q;
          m_ay_q  <= aby_q * aby_q;
          m_px_q  <= apx_q * abx_q;
          m_py_q  <= apy_q * aby_q;
          state_q <= S_SUM;
        end
        S_SUM: begin
          ab2_q   <= {1'b0, m_ax_q} + {1'b0, m_ay_q};
          dot_q   <= {m_px_q[49], m_px_q} + {m_py_q[49], m_py_q};
          state_q <= S_DEC;
        end
        S_DEC: begin
          if (ab2_q == '0 || dot_q[50] || dot_q == '0) begin
            offx_q  <= '0;
            offy_q  <= '0;
            state_q <= S_DX;
          end else if ($unsigned(dot_q) >= ab2_q) begin
            offx_q  <= 26'(abx_q);
            offy_q  <= 26'(aby_q);
            state_q <= S_DX;
          end else begin
            div_rem_q <= {1'b0, $unsigned(dot_q)};
            div_den_q <= ab2_q;
            div_n_q   <= 5'd24;
            hdiv_q    <= 1'b0;
            state_q   <= S_DIV;
          end
        end
        S_DIV: begin
          // shared restoring divider, one quotient bit per cycle
          div_rem_q <= div_ge ? (div_sh - {1'b0, div_den_q}) : div_sh;
          div_quo_q <= {div_quo_q[22:0], div_ge};
          div_n_q   <= div_n_q - 5'd1;
          if (div_n_q == 5'd1) begin
            state_q <= hdiv_q ? S_HU : S_SCL;
          end
        end
        S_SCL: begin
          offx_q  <= abx_q[24] ? -$signed(rndx) : $signed(rndx);
          offy_q  <= aby_q[24] ? -$signed(rndy) : $signed(rndy);
          state_q <= S_DX;
        end
        S_DX: begin
          dx_q    <= 26'(apx_q) - offx_q;
          dy_q    <= 26'(apy_q) - offy_q;
          state_q <= S_SQ;
        end
        S_SQ: begin
          sqx_q   <= $unsigned(52'(dx_q * dx_q));
          sqy_q   <= $unsigned(52'(dy_q * dy_q));
          state_q <= S_ACC;
        end
        S_ACC: begin
          if (!cfound_q || d2 < cmin_q) begin
            cmin_q   <= d2;
            cfound_q <= 1'b1;
          end
          if (!second_q && cur_q[48]) begin
            // closing edge back to the ring's first vertex
            seg_a_q  <= cur_q[47:0];
            seg_b_q  <= first_q[47:0];
            second_q <= 1'b1;
            state_q  <= S_DIF;
          end else if (second_q) begin
            if (!gfound_q || d2 < gbest_q || (cmin_q < gbest_q && cmin_q <= d2)) begin
              gbest_q <= (cmin_q < d2) ? cmin_q : d2;
              gfound_q <= 1'b1;
            end
            second_q   <= 1'b0;
            at_start_q <= 1'b1;
            state_q    <= S_NEXT;
          end else begin
            prev_q  <= cur_q;
            state_q <= S_NEXT;
          end
        end
        S_FIN: begin
          if (gfound_q) begin
            sq_v_q   <= gbest_q;
            sq_res_q <= '0;
            sq_bit_q <= 54'(1) << 52;
            state_q  <= S_SQRT;
          end else begin
            dist_q   <= DIST_MAX;
            status_q <= ST_NOSEG;
            state_q  <= S_HCHK;
          end
        end
        S_SQRT: begin
          if (sq_ge) begin
            sq_v_q <= 53'({1'b0, sq_v_q} - sq_trial);
          end
          sq_res_q <= sq_res_nx;
          sq_bit_q <= sq_bit_q >> 2;
          if (sq_bit_q == 54'd1) begin
            dist_q   <= (sq_res_nx > 54'(DIST_MAX)) ? DIST_MAX : sq_res_nx[24:0];
            status_q <= ST_OK;
            state_q  <= S_HCHK;
          end
        end
        S_HCHK: begin
          if (dmax_q == '0 || peak_q == '0) begin
            height_q <= '0;
            state_q  <= S_DONE;
          end else if (dist_q >= dmax_q) begin
            height_q <= peak_q;
            state_q  <= S_DONE;
          end else begin
            div_rem_q <= 52'(dist_q);
            div_den_q <= 51'(dmax_q);
            div_n_q   <= 5'd24;
            hdiv_q    <= 1'b1;
            state_q   <= S_DIV;
          end
        end
        S_HU: begin
          hu_q    <= 25'h100_0000 - {1'b0, div_quo_q};
          state_q <= S_HM1;
        end
        S_HM1: begin
          hp_q    <= 50'(hu_q) * 50'(hu_q);
          state_q <= S_HM2;
        end
        S_HM2: begin
          hp_q    <= 50'(hp_q[48:24]) * 50'(hp_q[48:24]);
          state_q <= S_HM3;
        end
        S_HM3: begin
          hp_q    <= 50'(peak_q) * 50'(25'h100_0000 - hp_q[48:24]);
          state_q <= S_HOUT;
        end
        S_HOUT: begin
          height_q <= hp_q[47:24];
          state_q  <= S_DONE;
        end
        S_DONE: begin
          out_valid_q  <= 1'b1;
          out_dist_q   <= dist_q;
          out_height_q <= height_q;
          out_status_q <= status_q;
          state_q      <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/outline_distance_arch_height_top.sv =====
// Top level of the outline distance and arch height block.
`default_nettype none
// Stores up to MaxVertices outline vertices (append, clear) and answers query
// points with the shortest distance to every closed contour plus a quartic
// arch height. A front end decodes and queues up to two requests, so new
// requests are taken while the back end works or a result waits. The back end
// handles one request at a time. A query reads each stored vertex (read,
// vertex and next states), runs each segment through the difference,
// multiply, sum, decide, offset, square and accumulate states, and uses the
// shared one-bit-per-cycle divider and the scaling step when the projection
// falls inside the segment; then come the square root and the height. The
// divider and the single table read port set the query time. Configuration
// writes land at once and should be made only while no request is in flight.
module outline_distance_arch_height_top #(
  parameter int MaxVertices = odah_pkg::MAX_VERTICES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         mode_i,
  input  logic signed [23:0] x_i,
  input  logic signed [23:0] y_i,
  input  logic               closes_contour_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [24:0]        distance_o,
  output logic [23:0]        height_o,
  output logic [1:0]         status_o,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [24:0]        cfg_data_i
);
  import odah_pkg::*;

  item_t item;
  logic  item_valid, item_pop;

  // Accept and decode requests; hold them in the short queue
  odah_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .mode_i          (mode_i),
    .x_i             (x_i),
    .y_i             (y_i),
    .closes_contour_i(closes_contour_i),
    .item_valid_o    (item_valid),
    .item_o          (item),
    .item_pop_i      (item_pop)
  );

  // Execute requests against the vertex table and drive the result register
  odah_back #(
    .MaxVertices(MaxVertices)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(item_valid),
    .item_i      (item),
    .item_pop_o  (item_pop),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .distance_o  (distance_o),
    .height_o    (height_o),
    .status_o    (status_o)
  );

  // An accepted request is still queued on the next cycle
  a_accept_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> item_valid)
    else $error("accepted request missing from queue");

  // No segments means a saturated distance
  a_noseg_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_NOSEG |-> distance_o == DIST_MAX)
    else $error("no-segment result without saturated distance");

  // A dropped append carries no distance or height
  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FULL |-> distance_o == '0 && height_o == '0)
    else $error("table-full result with nonzero payload");

endmodule
`default_nettype wire

// ===== tb/tb_outline_distance_arch_height_top.sv =====
// Testbench for the outline distance and arch height block: predicted results checked in order.
`timescale 1ns / 1ps
module tb_outline_distance_arch_height_top;
  import odah_pkg::*;

  localparam int TableDepth = 256;
  localparam longint unsigned One24 = 64'd1 << 24;

  typedef struct {
    logic [24:0] dist_val;
    logic [23:0] height;
    logic [1:0]  status;
  } answer_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [1:0]         mode_i = MODE_CLEAR;
  logic signed [23:0] x_i = '0;
  logic signed [23:0] y_i = '0;
  logic               closes_contour_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [24:0]        distance_o;
  logic [23:0]        height_o;
  logic [1:0]         status_o;
  logic               cfg_we_i = 1'b0;
  logic               cfg_idx_i = REG_MAX_DIST;
  logic [24:0]        cfg_data_i = '0;

  outline_distance_arch_height_top u_top (.*);

  // Period 2 ns.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow copy of the block's state and registers.
  logic [24:0]        dmax_q;
  logic [23:0]        peak_q;
  logic signed [23:0] vtx_x[TableDepth];
  logic signed [23:0] vtx_y[TableDepth];
  bit                 vtx_close[TableDepth];
  int                 vtx_count;

  answer_t answer_q[$];
  int      err_cnt;
  int      req_cnt;
  int      burst_left;
  int      gap_len;

  task automatic report_mismatch(input string what);
    err_cnt++;
    $display("mismatch: %s", what);
  endtask

  // Squared distance from p to segment a->b, all Q.8.
  function automatic longint unsigned seg_dist2(longint px, longint py, longint ax,
                                                longint ay, longint bx, longint by);
    longint abx, aby, apx, apy, dot, qx, qy, dx, dy;
    longint unsigned ab2, rem, t, mx, my;
    abx = bx - ax;
    aby = by - ay;
    apx = px - ax;
    apy = py - ay;
    ab2 = abx * abx + aby * aby;
    dot = apx * abx + apy * aby;
    if (ab2 == 0 || dot <= 0) begin
      qx = ax;
      qy = ay;
    end else if (longint'(dot) >= longint'(ab2)) begin
      qx = bx;
      qy = by;
    end else begin
      rem = dot;
      t = 0;
      for (int k = 0; k < 24; k++) begin
        rem = rem << 1;
        t = t << 1;
        if (rem >= ab2) begin
          rem -= ab2;
          t |= 1;
        end
      end
      // Round the offset half away from zero.
      mx = ((abx < 0 ? -abx : abx) * t + (64'd1 << 23)) >> 24;
      my = ((aby < 0 ? -aby : aby) * t + (64'd1 << 23)) >> 24;
      qx = ax + (abx < 0 ? -longint'(mx) : longint'(mx));
      qy = ay + (aby < 0 ? -longint'(my) : longint'(my));
    end
    dx = px - qx;
    dy = py - qy;
    return dx * dx + dy * dy;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [23:0] arch_of(longint unsigned d);
    longint unsigned t, u, u2, u4;
    if (dmax_q == 0 || peak_q == 0) return '0;
    if (d >= dmax_q) return peak_q;
    t = (d << 24) / dmax_q;
    u = One24 - t;
    u2 = (u * u) >> 24;
    u4 = (u2 * u2) >> 24;
    return 24'((longint'(peak_q) * (One24 - u4)) >> 24);
  endfunction

  // Apply one accepted request to the shadow state and queue its answer.
  task automatic apply_request(logic [1:0] mode, logic signed [23:0] x,
                               logic signed [23:0] y, logic c);
    answer_t a;
    longint unsigned best, d2, d;
    bit found;
    int s, nb;
    a = '{dist_val: '0, height: '0, status: ST_OK};
    case (mode)
      MODE_CLEAR: vtx_count = 0;
      MODE_APPEND: begin
        if (vtx_count < TableDepth) begin
          vtx_x[vtx_count] = x;
          vtx_y[vtx_count] = y;
          vtx_close[vtx_count] = c;
          vtx_count++;
        end else begin
          a.status = ST_FULL;
        end
      end
      MODE_QUERY: begin
        found = 0;
        best = 0;
        s = 0;
        for (int i = 0; i < vtx_count; i++) begin
          if (vtx_close[i]) begin
            // Rings of one vertex are skipped.
            if (i > s) begin
              for (int j = s; j <= i; j++) begin
                nb = (j == i) ? s : j + 1;
                d2 = seg_dist2(x, y, vtx_x[j], vtx_y[j], vtx_x[nb], vtx_y[nb]);
                if (!found || d2 < best) begin
                  best = d2;
                  found = 1;
                end
              end
            end
            s = i + 1;
          end
        end
        if (found) begin
          d = int_sqrt(best);
          if (d > DIST_MAX) d = DIST_MAX;
        end else begin
          d = DIST_MAX;
          a.status = ST_NOSEG;
        end
        a.dist_val = 25'(d);
        a.height = arch_of(d);
      end
      default: ;  // unused mode: all zero, state held
    endcase
    answer_q = {answer_q, a};
  endtask

  // Drive one request, hold it until taken, then at a burst's end maybe idle for a gap.
  task automatic send_req(logic [1:0] mode, logic signed [23:0] x,
                          logic signed [23:0] y, logic c);
    @(negedge clk_i);
    in_valid_i = 1'b1;
    mode_i = mode;
    x_i = x;
    y_i = y;
    closes_contour_i = c;
    do @(posedge clk_i); while (!in_ready_o);
    apply_request(mode, x, y, c);
    if (mode != OP_NONE) req_cnt++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap_len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap_len > 0) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
        repeat (gap_len - 1) @(negedge clk_i);
      end
    end
  endtask

  // Hold off until every queued answer has come back.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (answer_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [24:0] data);
    drain();
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    if (idx == REG_MAX_DIST) dmax_q = data;
    else peak_q = data[23:0];
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Receiver stalls on its own pattern: fully open, random, or long holds.
  initial begin
    int pat;
    forever begin
      pat = $urandom_range(0, 3);
      repeat ($urandom_range(16, 80)) begin
        @(negedge clk_i);
        case (pat)
          0: out_ready_i = 1'b1;
          1: out_ready_i = 1'($urandom_range(0, 1));
          2: out_ready_i = ($urandom_range(0, 7) == 0);
          default: out_ready_i = ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Compare each taken result with the oldest answer.
  always @(posedge clk_i) begin
    answer_t a;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (answer_q.size() == 0) begin
        report_mismatch("result with no request pending");
      end else begin
        a = answer_q.pop_front();
        if (distance_o !== a.dist_val)
          report_mismatch($sformatf("distance %0d want %0d", distance_o, a.dist_val));
        if (height_o !== a.height)
          report_mismatch($sformatf("height %0d want %0d", height_o, a.height));
        if (status_o !== a.status)
          report_mismatch($sformatf("status %0d want %0d", status_o, a.status));
      end
    end
  end

  function automatic logic signed [23:0] pick_coord();
    case ($urandom_range(0, 5))
      0, 1: return 24'($urandom());
      2: return 24'sd8388607;
      3: return -24'sd8388608;
      default: return 24'($signed($urandom_range(0, 16383)) - 8192);
    endcase
  endfunction

  function automatic logic [24:0] pick_dmax();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return DIST_MAX;
      2: return 25'($urandom());
      default: return 25'($urandom_range(1, 20000));
    endcase
  endfunction

  task automatic test_directed();
    // Empty table with zero registers: saturated distance, zero height.
    send_req(MODE_QUERY, 24'sd0, 24'sd0, 1'b0);
    write_reg(REG_MAX_DIST, DIST_MAX);
    write_reg(REG_ARCH_PEAK, 25'hFF_FFFF);
    send_req(MODE_QUERY, 24'sd8388607, -24'sd8388608, 1'b1);
    // Single-vertex ring is skipped.
    send_req(MODE_APPEND, 24'sd100, 24'sd100, 1'b1);
    send_req(MODE_QUERY, 24'sd0, 24'sd0, 1'b0);
    // Triangle, then an unclosed tail that queries ignore.
    send_req(MODE_APPEND, 24'sd0, 24'sd0, 1'b0);
    send_req(MODE_APPEND, 24'sd2560, 24'sd0, 1'b0);
    send_req(MODE_APPEND, 24'sd0, 24'sd2560, 1'b1);
    send_req(MODE_APPEND, -24'sd8388608, -24'sd8388608, 1'b0);
    send_req(MODE_QUERY, 24'sd700, 24'sd700, 1'b0);
    send_req(MODE_QUERY, -24'sd500, 24'sd3000, 1'b0);
    send_req(MODE_QUERY, 24'sd8388607, 24'sd8388607, 1'b0);
    // Unused mode leaves state alone.
    send_req(OP_NONE, 24'sd1, -24'sd1, 1'b1);
    write_reg(REG_MAX_DIST, 25'd1000);
    write_reg(REG_ARCH_PEAK, 25'd256);
    // Zero-length segments from repeated vertices.
    send_req(MODE_CLEAR, 24'sd0, 24'sd0, 1'b0);
    send_req(MODE_APPEND, 24'sd50, 24'sd50, 1'b0);
    send_req(MODE_APPEND, 24'sd50, 24'sd50, 1'b1);
    send_req(MODE_QUERY, 24'sd300, -24'sd20, 1'b0);
    send_req(MODE_QUERY, 24'sd50, 24'sd50, 1'b0);
    // Opposite coordinate extremes as one segment.
    send_req(MODE_APPEND, -24'sd8388608, 24'sd8388607, 1'b0);
    send_req(MODE_APPEND, 24'sd8388607, -24'sd8388608, 1'b1);
    send_req(MODE_QUERY, -24'sd8388608, -24'sd8388608, 1'b0);
    send_req(MODE_CLEAR, 24'sd0, 24'sd0, 1'b0);
    send_req(MODE_QUERY, 24'sd5, 24'sd5, 1'b0);
  endtask

  // Fill the table to its limit, then overflow it.
  task automatic test_full_table();
    write_reg(REG_MAX_DIST, 25'd1);
    write_reg(REG_ARCH_PEAK, 25'd1);
    send_req(MODE_CLEAR, 24'sd0, 24'sd0, 1'b0);
    for (int i = 0; i < TableDepth + 3; i++)
      send_req(MODE_APPEND, pick_coord(), pick_coord(), ($urandom_range(0, 3) == 0));
    repeat (2) send_req(MODE_QUERY, pick_coord(), pick_coord(), 1'b0);
    send_req(MODE_CLEAR, 24'sd0, 24'sd0, 1'b0);
  endtask

  // Well-formed contour sets with random content, plus some noise.
  task automatic test_random();
    int nc, len;
    while (req_cnt < 1100) begin
      write_reg(REG_MAX_DIST, pick_dmax());
      write_reg(REG_ARCH_PEAK, ($urandom_range(0, 4) == 0) ? 25'hFF_FFFF :
                ($urandom_range(0, 3) == 0) ? 25'd0 : 25'($urandom()));
      repeat ($urandom_range(3, 8)) begin
        if (vtx_count > 20 || $urandom_range(0, 2) != 0)
          send_req(MODE_CLEAR, pick_coord(), pick_coord(), 1'($urandom_range(0, 1)));
        nc = $urandom_range(0, 3);
        for (int k = 0; k < nc; k++) begin
          len = $urandom_range(1, 5);
          for (int v = 0; v < len; v++)
            send_req(MODE_APPEND, pick_coord(), pick_coord(), v == len - 1);
        end
        if ($urandom_range(0, 3) == 0)
          send_req(MODE_APPEND, pick_coord(), pick_coord(), 1'b0);
        if ($urandom_range(0, 5) == 0)
          send_req(OP_NONE, pick_coord(), pick_coord(), 1'($urandom_range(0, 1)));
        repeat ($urandom_range(1, 5))
          send_req(MODE_QUERY, pick_coord(), pick_coord(), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    err_cnt = 0;
    req_cnt = 0;
    burst_left = 0;
    vtx_count = 0;
    dmax_q = '0;
    peak_q = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (4) @(negedge clk_i);
    test_directed();
    test_full_table();
    test_random();
    drain();
    repeat (200) @(negedge clk_i);
    if (err_cnt == 0 && answer_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("status: fail");
    $finish;
  end

endmodule
